FILE: hdl/gcd_pkg.sv
// ============================================================================
// gcd_pkg - shared types and constants for the great-circle distance unit
// Fixed-point formats, turn constants, the degree-to-radian factor and the
// CORDIC arctangent table.
// ============================================================================
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS  = 30;
    localparam int CORDIC_STEPS_DEF = 32;

    // Datapath widths
    localparam int VW  = 34;   // signed CORDIC and product word
    localparam int AW  = 31;   // folded angle and square-root operand
    localparam int RW  = 24;   // sphere radius in meters
    localparam int RKW = 35;   // radius times 2000
    localparam int DW  = 36;   // distance in millimeters

    // Pipeline depths of the individual units
    localparam int RED_LAT    = 4;
    localparam int RAD_LAT    = 2;
    localparam int MUL_LAT    = 3;
    localparam int SQRT_STEPS = ANGLE_FRAC_BITS + 1;

    // Right shifts after the radian product: half angle for the sines
    localparam int SIN_SHIFT = 93 - ANGLE_FRAC_BITS;
    localparam int COS_SHIFT = 92 - ANGLE_FRAC_BITS;

    localparam logic [RW-1:0]  RADIUS_RESET   = 24'd6371000;
    localparam logic [RKW-1:0] RADIUS_K_RESET = RKW'(64'd6371000 * 64'd2000);

    localparam logic [31:0] FULL_TURN    = 32'd3600000000;
    localparam logic [31:0] HALF_TURN    = 32'd1800000000;
    localparam logic [31:0] QUARTER_TURN = 32'd900000000;

    // pi / 1.8e9 in Q92, split into upper and lower words
    localparam logic [31:0] RAD_HI = 32'd2012227627;
    localparam logic [31:0] RAD_LO = 32'd1046448311;

    localparam logic [AW-1:0] ONE_Q     = AW'(64'd1 << ANGLE_FRAC_BITS);
    localparam logic [VW-1:0] CORDIC_X0 = 34'd652032874;

    typedef logic signed [VW-1:0] t_vec;
    typedef logic [AW-1:0]        t_angle;

    // Folded angles leaving the reduction unit
    typedef struct packed {
        t_angle sd;      // |dlat| folded to a half turn
        t_angle sl;      // |dlon| folded to a half turn
        t_angle ca;      // |lat_a| folded to a quarter turn
        t_angle cb;      // |lat_b| folded to a quarter turn
        logic   neg_a;   // cosine of lat_a changes sign
        logic   neg_b;
    } t_red;

    // atan(2^-i) rounded to Q30
    function automatic logic [31:0] atan_q(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd843314857;
            1:       v = 32'd497837829;
            2:       v = 32'd263043837;
            3:       v = 32'd133525159;
            4:       v = 32'd67021687;
            5:       v = 32'd33543516;
            6:       v = 32'd16775851;
            7:       v = 32'd8388437;
            8:       v = 32'd4194283;
            9:       v = 32'd2097149;
            31:      v = 32'd1;
            default: begin
                if (i inside {[10:30]}) begin
                    v = 32'd1 << (30 - i);
                end else begin
                    v = 32'd0;
                end
            end
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/great_circle_distance_unit.sv
// ============================================================================
// great_circle_distance_unit - haversine distance between two positions
// Pipelined CORDIC and square-root cell rows, one pair per clock if unstalled.
// ============================================================================
//
//  channel   dir  width  contents (lowest bit first)
//  s_axis    in   128    lat_a[30:0] lon_a[62:31] lat_b[93:63] lon_b[125:94]
//  m_axis    out  40     distance_mm[35:0]
//  cfg       in   24     sphere_radius_m, written when i_cfg_wen is high
//
//  One position pair enters per clock while m_axis is not stalled; most
//  stages lie in the two CORDIC cell rows and the 31-cell root row.
//  A result held at m_axis stalls every stage and drops s_axis_tready.
//  Reset (synchronous) empties the pipeline and restores the Earth radius.
//
module great_circle_distance_unit
    import gcd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // lat_a, lon_a, lat_b, lon_b
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [39:0]   m_axis_tdata,   // distance_mm
    input  logic          i_cfg_wen,
    input  logic [RW-1:0] i_cfg_wdata
);

    localparam int ROT_END = RED_LAT + RAD_LAT + CORDIC_STEPS;
    localparam int HS_IDX  = ROT_END + 2 * MUL_LAT + 2 - 1;
    localparam int LAT     = HS_IDX + 1 + SQRT_STEPS + CORDIC_STEPS + 2;
    localparam int NDLY    = RAD_LAT + CORDIC_STEPS;

    logic           w_ce;
    logic [LAT-1:0] r_vld;
    logic [RKW-1:0] r_radius_k;

    t_red           w_red;
    t_angle         w_ang   [4];
    t_angle         w_rad   [4];
    logic [1:0]     r_neg_dly [NDLY];

    t_vec           w_rx [4][CORDIC_STEPS+1];
    t_vec           w_ry [4][CORDIC_STEPS+1];
    t_vec           w_rz [4][CORDIC_STEPS+1];

    t_vec           w_sd2, w_sl2, w_cc, w_t;
    t_vec           r_sd2_dly [MUL_LAT];
    logic signed [VW:0] w_hsum;
    t_angle         r_h, r_hx, r_hy;

    t_angle         w_sv    [2][SQRT_STEPS+1];
    logic [33:0]    w_srem  [2][SQRT_STEPS+1];
    logic [31:0]    w_sroot [2][SQRT_STEPS+1];

    t_vec           w_vx [CORDIC_STEPS+1];
    t_vec           w_vy [CORDIC_STEPS+1];
    t_vec           w_vz [CORDIC_STEPS+1];

    t_angle         w_zc;
    logic [62:0]    r_pl;
    logic [33:0]    r_ph;
    logic [66:0]    w_fsum;
    logic [DW-1:0]  r_dist;

    // ---------------------------------------------------------------- control
    assign w_ce          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_ce;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // The radius is kept premultiplied by 2000 (meters to millimeters, and
    // the factor two of the haversine formula).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_k <= RADIUS_K_RESET;
        end else if (i_cfg_wen) begin
            r_radius_k <= (RKW'(i_cfg_wdata) << 11) - (RKW'(i_cfg_wdata) << 5)
                        - (RKW'(i_cfg_wdata) << 4);
        end
    end

    // ------------------------------------------------------ angle preparation
    gcd_reduce u_reduce (
        .i_clk   (i_clk),
        .i_ce    (w_ce),
        .i_lat_a (s_axis_tdata[30:0]),
        .i_lon_a (s_axis_tdata[62:31]),
        .i_lat_b (s_axis_tdata[93:63]),
        .i_lon_b (s_axis_tdata[125:94]),
        .o_red   (w_red)
    );

    assign w_ang[0] = w_red.sd;
    assign w_ang[1] = w_red.sl;
    assign w_ang[2] = w_red.ca;
    assign w_ang[3] = w_red.cb;

    generate
        for (genvar l = 0; l < 4; l++) begin : g_rad
            gcd_rad #(.SHIFT(l < 2 ? SIN_SHIFT : COS_SHIFT)) u_rad (
                .i_clk (i_clk),
                .i_ce  (w_ce),
                .i_ang (w_ang[l]),
                .o_ang (w_rad[l])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_neg_dly[0] <= {w_red.neg_b, w_red.neg_a};
            for (int k = 1; k < NDLY; k++) begin
                r_neg_dly[k] <= r_neg_dly[k-1];
            end
        end
    end

    // ------------------------------------------------ CORDIC rotation rows
    // Lanes: sine of half dlat, sine of half dlon, cosine of each latitude.
    generate
        for (genvar l = 0; l < 4; l++) begin : g_lane
            assign w_rx[l][0] = CORDIC_X0;
            assign w_ry[l][0] = '0;
            assign w_rz[l][0] = t_vec'(w_rad[l]);
            for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_rot
                gcd_rot_cell #(.STEP(s)) u_cell (
                    .i_clk (i_clk),
                    .i_ce  (w_ce),
                    .i_x   (w_rx[l][s]),
                    .i_y   (w_ry[l][s]),
                    .i_z   (w_rz[l][s]),
                    .o_x   (w_rx[l][s+1]),
                    .o_y   (w_ry[l][s+1]),
                    .o_z   (w_rz[l][s+1])
                );
            end
        end
    endgenerate

    // ------------------------------------------------------- haversine term
    gcd_smul u_sd2 (
        .i_clk (i_clk), .i_ce (w_ce),
        .i_a (w_ry[0][CORDIC_STEPS]), .i_b (w_ry[0][CORDIC_STEPS]),
        .i_flip (1'b0), .o_p (w_sd2)
    );

    gcd_smul u_sl2 (
        .i_clk (i_clk), .i_ce (w_ce),
        .i_a (w_ry[1][CORDIC_STEPS]), .i_b (w_ry[1][CORDIC_STEPS]),
        .i_flip (1'b0), .o_p (w_sl2)
    );

    gcd_smul u_cc (
        .i_clk (i_clk), .i_ce (w_ce),
        .i_a (w_rx[2][CORDIC_STEPS]), .i_b (w_rx[3][CORDIC_STEPS]),
        .i_flip (r_neg_dly[NDLY-1][0] ^ r_neg_dly[NDLY-1][1]), .o_p (w_cc)
    );

    gcd_smul u_t (
        .i_clk (i_clk), .i_ce (w_ce),
        .i_a (w_cc), .i_b (w_sl2),
        .i_flip (1'b0), .o_p (w_t)
    );

    assign w_hsum = {r_sd2_dly[MUL_LAT-1][VW-1], r_sd2_dly[MUL_LAT-1]} + {w_t[VW-1], w_t};

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_sd2_dly[0] <= w_sd2;
            for (int k = 1; k < MUL_LAT; k++) begin
                r_sd2_dly[k] <= r_sd2_dly[k-1];
            end
            // Rounding can push h slightly outside the unit interval.
            if (w_hsum[VW]) begin
                r_h <= '0;
            end else if (w_hsum > $signed({4'd0, ONE_Q})) begin
                r_h <= ONE_Q;
            end else begin
                r_h <= w_hsum[AW-1:0];
            end
            r_hx <= ONE_Q - r_h;
            r_hy <= r_h;
        end
    end

    // ------------------------------------------------------- square roots
    generate
        for (genvar r = 0; r < 2; r++) begin : g_sq
            assign w_sv[r][0]    = (r == 0) ? r_hx : r_hy;
            assign w_srem[r][0]  = '0;
            assign w_sroot[r][0] = '0;
            for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_digit
                gcd_sqrt_cell #(.POS(ANGLE_FRAC_BITS - k)) u_cell (
                    .i_clk  (i_clk),
                    .i_ce   (w_ce),
                    .i_v    (w_sv[r][k]),
                    .i_rem  (w_srem[r][k]),
                    .i_root (w_sroot[r][k]),
                    .o_v    (w_sv[r][k+1]),
                    .o_rem  (w_srem[r][k+1]),
                    .o_root (w_sroot[r][k+1])
                );
            end
        end
    endgenerate

    // ------------------------------------------------ arcsine by vectoring
    assign w_vx[0] = t_vec'(w_sroot[0][SQRT_STEPS]);
    assign w_vy[0] = t_vec'(w_sroot[1][SQRT_STEPS]);
    assign w_vz[0] = '0;

    generate
        for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_vec
            gcd_vec_cell #(.STEP(s)) u_cell (
                .i_clk (i_clk),
                .i_ce  (w_ce),
                .i_x   (w_vx[s]),
                .i_y   (w_vy[s]),
                .i_z   (w_vz[s]),
                .o_x   (w_vx[s+1]),
                .o_y   (w_vy[s+1]),
                .o_z   (w_vz[s+1])
            );
        end
    endgenerate

    // ------------------------------------------------------- final scaling
    assign w_zc   = w_vz[CORDIC_STEPS][VW-1] ? '0 : w_vz[CORDIC_STEPS][AW-1:0];
    assign w_fsum = {1'b0, r_ph, 32'd0} + 67'(r_pl)
                  + (67'd1 << (ANGLE_FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_pl   <= 63'(w_zc) * 63'(r_radius_k[31:0]);
            r_ph   <= 34'(w_zc) * 34'(r_radius_k[RKW-1:32]);
            r_dist <= w_fsum[ANGLE_FRAC_BITS+DW-1:ANGLE_FRAC_BITS];
        end
    end

    assign m_axis_tdata = {4'd0, r_dist};

    // ------------------------------------------------------------ assertions
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(r_vld))
        else $error("pipeline moved while the result was held");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted request did not enter the pipeline");

    a_root_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[HS_IDX] |-> ((32'(r_hx) + 32'(r_hy)) == 32'(ONE_Q)))
        else $error("square-root operands do not sum to one");

endmodule

FILE: hdl/gcd_reduce.sv
// ============================================================================
// gcd_reduce - angle differences and range reduction
// Forms the latitude and longitude differences, takes magnitudes, reduces
// them to a half turn and folds both latitudes to a quarter turn.
// ============================================================================
module gcd_reduce
    import gcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [30:0] i_lat_a,
    input  logic [31:0] i_lon_a,
    input  logic [30:0] i_lat_b,
    input  logic [31:0] i_lon_b,
    output t_red        o_red
);

    logic [31:0] r_dlat;
    logic [32:0] r_dlon;
    logic [30:0] r_mag_a, r_mag_b;
    logic [31:0] r_adlat, r_adlon;
    logic [31:0] r_mlat, r_mlon;
    t_angle      r_ca2, r_cb2, r_ca3, r_cb3;
    logic        r_na2, r_nb2, r_na3, r_nb3;
    t_red        r_out;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            // Stage 1: differences and latitude magnitudes
            r_dlat  <= {i_lat_b[30], i_lat_b} - {i_lat_a[30], i_lat_a};
            r_dlon  <= {i_lon_b[31], i_lon_b} - {i_lon_a[31], i_lon_a};
            r_mag_a <= i_lat_a[30] ? (~i_lat_a + 31'd1) : i_lat_a;
            r_mag_b <= i_lat_b[30] ? (~i_lat_b + 31'd1) : i_lat_b;

            // Stage 2: difference magnitudes, quarter-turn fold of latitudes
            r_adlat <= r_dlat[31] ? (~r_dlat + 32'd1) : r_dlat;
            r_adlon <= r_dlon[32] ? 32'(~r_dlon + 33'd1) : r_dlon[31:0];
            if ({1'b0, r_mag_a} > QUARTER_TURN) begin
                r_ca2 <= AW'(HALF_TURN - {1'b0, r_mag_a});
                r_na2 <= 1'b1;
            end else begin
                r_ca2 <= r_mag_a;
                r_na2 <= 1'b0;
            end
            if ({1'b0, r_mag_b} > QUARTER_TURN) begin
                r_cb2 <= AW'(HALF_TURN - {1'b0, r_mag_b});
                r_nb2 <= 1'b1;
            end else begin
                r_cb2 <= r_mag_b;
                r_nb2 <= 1'b0;
            end

            // Stage 3: modulo a full turn
            r_mlat <= (r_adlat >= FULL_TURN) ? (r_adlat - FULL_TURN) : r_adlat;
            r_mlon <= (r_adlon >= FULL_TURN) ? (r_adlon - FULL_TURN) : r_adlon;
            r_ca3  <= r_ca2;
            r_cb3  <= r_cb2;
            r_na3  <= r_na2;
            r_nb3  <= r_nb2;

            // Stage 4: sin^2 of the half angle is symmetric about a half turn
            r_out.sd    <= AW'((r_mlat > HALF_TURN) ? (FULL_TURN - r_mlat) : r_mlat);
            r_out.sl    <= AW'((r_mlon > HALF_TURN) ? (FULL_TURN - r_mlon) : r_mlon);
            r_out.ca    <= r_ca3;
            r_out.cb    <= r_cb3;
            r_out.neg_a <= r_na3;
            r_out.neg_b <= r_nb3;
        end
    end

    assign o_red = r_out;

endmodule

FILE: hdl/gcd_rad.sv
// ============================================================================
// gcd_rad - 1e-7 degree units to Q30 radians, halved when SHIFT is SIN_SHIFT
// Two partial products against the Q92 factor, then one rounded shift.
// ============================================================================
module gcd_rad
    import gcd_pkg::*;
#(
    parameter int SHIFT = SIN_SHIFT
)(
    input  logic   i_clk,
    input  logic   i_ce,
    input  t_angle i_ang,
    output t_angle o_ang
);

    logic [62:0] r_ph, r_pl;
    t_angle      r_ang;
    logic [94:0] w_sum;

    assign w_sum = {r_ph, 32'd0} + 95'(r_pl) + (95'd1 << (SHIFT - 1));

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ph  <= 63'(i_ang) * 63'(RAD_HI);
            r_pl  <= 63'(i_ang) * 63'(RAD_LO);
            r_ang <= w_sum[SHIFT+AW-1:SHIFT];
        end
    end

    assign o_ang = r_ang;

endmodule

FILE: hdl/gcd_rot_cell.sv
// ============================================================================
// gcd_rot_cell - one CORDIC rotation step
// Turns the vector toward the residual angle by atan(2^-STEP).
// ============================================================================
module gcd_rot_cell
    import gcd_pkg::*;
#(
    parameter int STEP = 0
)(
    input  logic i_clk,
    input  logic i_ce,
    input  t_vec i_x,
    input  t_vec i_y,
    input  t_vec i_z,
    output t_vec o_x,
    output t_vec o_y,
    output t_vec o_z
);

    localparam t_vec ANG = $signed({2'b00, atan_q(STEP)});

    t_vec r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (!i_z[VW-1]) begin
                r_x <= i_x - (i_y >>> STEP);
                r_y <= i_y + (i_x >>> STEP);
                r_z <= i_z - ANG;
            end else begin
                r_x <= i_x + (i_y >>> STEP);
                r_y <= i_y - (i_x >>> STEP);
                r_z <= i_z + ANG;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

FILE: hdl/gcd_vec_cell.sv
// ============================================================================
// gcd_vec_cell - one CORDIC vectoring step
// Drives y toward zero and accumulates the angle turned through.
// ============================================================================
module gcd_vec_cell
    import gcd_pkg::*;
#(
    parameter int STEP = 0
)(
    input  logic i_clk,
    input  logic i_ce,
    input  t_vec i_x,
    input  t_vec i_y,
    input  t_vec i_z,
    output t_vec o_x,
    output t_vec o_y,
    output t_vec o_z
);

    localparam t_vec ANG = $signed({2'b00, atan_q(STEP)});

    t_vec r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (!i_y[VW-1]) begin
                r_x <= i_x + (i_y >>> STEP);
                r_y <= i_y - (i_x >>> STEP);
                r_z <= i_z + ANG;
            end else begin
                r_x <= i_x - (i_y >>> STEP);
                r_y <= i_y + (i_x >>> STEP);
                r_z <= i_z - ANG;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

FILE: hdl/gcd_sqrt_cell.sv
// ============================================================================
// gcd_sqrt_cell - one digit of a restoring square root
// Brings down the bit pair at position POS of v * 2^30 and decides one
// root bit.
// ============================================================================
module gcd_sqrt_cell
    import gcd_pkg::*;
#(
    parameter int POS = 0
)(
    input  logic        i_clk,
    input  logic        i_ce,
    input  t_angle      i_v,
    input  logic [33:0] i_rem,
    input  logic [31:0] i_root,
    output t_angle      o_v,
    output logic [33:0] o_rem,
    output logic [31:0] o_root
);

    localparam int HI     = 2 * POS + 1 - ANGLE_FRAC_BITS;
    localparam int LO     = 2 * POS - ANGLE_FRAC_BITS;
    localparam bit HI_OK  = (HI >= 0) && (HI < AW);
    localparam bit LO_OK  = (LO >= 0) && (LO < AW);
    localparam int HI_IDX = HI_OK ? HI : 0;
    localparam int LO_IDX = LO_OK ? LO : 0;

    logic        w_b1, w_b0;
    logic [33:0] w_rem, w_trial;
    t_angle      r_v;
    logic [33:0] r_rem;
    logic [31:0] r_root;

    assign w_b1    = HI_OK ? i_v[HI_IDX] : 1'b0;
    assign w_b0    = LO_OK ? i_v[LO_IDX] : 1'b0;
    assign w_rem   = {i_rem[31:0], w_b1, w_b0};
    assign w_trial = {i_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_v <= i_v;
            if (w_rem >= w_trial) begin
                r_rem  <= w_rem - w_trial;
                r_root <= {i_root[30:0], 1'b1};
            end else begin
                r_rem  <= w_rem;
                r_root <= {i_root[30:0], 1'b0};
            end
        end
    end

    assign o_v    = r_v;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

FILE: hdl/gcd_smul.sv
// ============================================================================
// gcd_smul - signed Q30 product
// Sign and magnitude split, one 32 x 32 multiply, then rounding half away
// from zero back to Q30. An extra sign flip is folded into the result sign.
// ============================================================================
module gcd_smul
    import gcd_pkg::*;
(
    input  logic i_clk,
    input  logic i_ce,
    input  t_vec i_a,
    input  t_vec i_b,
    input  logic i_flip,
    output t_vec o_p
);

    logic [31:0] r_ma, r_mb;
    logic        r_neg1, r_neg2;
    logic [63:0] r_prod;
    t_vec        r_p;
    t_vec        w_mag;

    assign w_mag = t_vec'((r_prod + (64'd1 << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ma   <= i_a[VW-1] ? 32'(-i_a) : i_a[31:0];
            r_mb   <= i_b[VW-1] ? 32'(-i_b) : i_b[31:0];
            r_neg1 <= i_a[VW-1] ^ i_b[VW-1] ^ i_flip;

            r_prod <= 64'(r_ma) * 64'(r_mb);
            r_neg2 <= r_neg1;

            r_p    <= r_neg2 ? -w_mag : w_mag;
        end
    end

    assign o_p = r_p;

endmodule
